// ===== rtl/core/cffsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cffsa_pkg
// Shared constants and controller/datapath handshake structs for the
// circular first-free slot allocator.
// ----------------------------------------------------------------------------
package cffsa_pkg;

  localparam int SLOT_W    = 10;               // slot index field width
  localparam int SLOTS     = 1 << SLOT_W;
  localparam int BIT_W     = 5;                // slot bits per occupancy word (log2)
  localparam int WORD_W    = 1 << BIT_W;
  localparam int WIDX_W    = SLOT_W - BIT_W;   // word index width
  localparam int NUM_WORDS = 1 << WIDX_W;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch request, read its word
    logic rd_found;    // read word chosen by the word-level search
    logic take_cand;   // take bit from masked search of the preferred word
    logic take_free;   // take lowest free bit of the found word
    logic rot_en;      // rotate the free-word vector to start after the word
    logic commit_set;  // mark bit used, load grant result
    logic commit_clr;  // clear bit (release)
    logic load_full;   // load table-full result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_release;
    logic cand_any;    // a free slot at or after the preferred bit in its word
    logic all_full;
    logic out_free;    // result register can take a new transaction
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/cffsa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cffsa_req_if / cffsa_rsp_if
// Valid/ready channels carrying allocate/release requests and grant results.
// ----------------------------------------------------------------------------
interface cffsa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [cffsa_pkg::SLOT_W-1:0] slot_index;

  modport source (output valid, output operation, output slot_index, input ready);
  modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

interface cffsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cffsa_pkg::SLOT_W-1:0] granted_slot;
  logic                        table_full;

  modport source (output valid, output granted_slot, output table_full, input ready);
  modport sink   (input valid, input granted_slot, input table_full, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cffsa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cffsa_ctrl
// Sequencer: steps one request through read, word search and commit.
// ----------------------------------------------------------------------------
module cffsa_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      req_valid_i,
  output logic                     req_ready_o,
  input  wire cffsa_pkg::status_t  status_i,
  output cffsa_pkg::cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ROTATE,
    S_FIND,
    S_PICK,
    S_COMMIT,
    S_RELEASE,
    S_FULL
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.is_release) begin
          state_d = S_RELEASE;
        end else if (status_i.cand_any) begin
          cmd_o.take_cand = 1'b1;
          state_d         = S_COMMIT;
        end else if (status_i.all_full) begin
          state_d = S_FULL;
        end else begin
          cmd_o.rot_en = 1'b1;
          state_d      = S_ROTATE;
        end
      end
      S_ROTATE: begin
        cmd_o.rd_found = 1'b1;
        state_d        = S_FIND;
      end
      S_FIND: begin
        // read data of the found word lands this cycle
        state_d = S_PICK;
      end
      S_PICK: begin
        cmd_o.take_free = 1'b1;
        state_d         = S_COMMIT;
      end
      S_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit_set = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_RELEASE: begin
        cmd_o.commit_clr = 1'b1;
        state_d          = S_IDLE;
      end
      S_FULL: begin
        if (status_i.out_free) begin
          cmd_o.load_full = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cffsa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cffsa_dp
// Occupancy store (words of slot bits), word-full summary, bit and word
// searches, and the result register.
// ----------------------------------------------------------------------------
module cffsa_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              req_operation_i,
  input  wire  [cffsa_pkg::SLOT_W-1:0]     req_slot_index_i,
  input  wire cffsa_pkg::cmd_t             cmd_i,
  output cffsa_pkg::status_t               status_o,
  output logic                             rsp_valid_o,
  input  wire                              rsp_ready_i,
  output logic [cffsa_pkg::SLOT_W-1:0]     rsp_granted_slot_o,
  output logic                             rsp_table_full_o
);

  localparam int BIT_W     = cffsa_pkg::BIT_W;
  localparam int WORD_W    = cffsa_pkg::WORD_W;
  localparam int WIDX_W    = cffsa_pkg::WIDX_W;
  localparam int NUM_WORDS = cffsa_pkg::NUM_WORDS;
  localparam int SLOT_W    = cffsa_pkg::SLOT_W;

  // lowest set bit of a word
  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // lowest set bit of the word vector
  function automatic logic [WIDX_W-1:0] low_word(input logic [NUM_WORDS-1:0] v);
    logic [WIDX_W-1:0] r;
    r = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WIDX_W'(i);
    end
    return r;
  endfunction

  logic [WORD_W-1:0]    mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] wfull_q;
  logic [WORD_W-1:0]    rd_q;
  logic                 op_q;
  logic [WIDX_W-1:0]    widx_q;
  logic [BIT_W-1:0]     bidx_q;
  logic [NUM_WORDS-1:0] rot_q;

  logic [WIDX_W-1:0]    rd_addr;
  logic [WIDX_W-1:0]    found_widx;
  logic [WIDX_W-1:0]    rot_sh;
  logic [WORD_W-1:0]    cand;
  logic [WORD_W-1:0]    bit_oh;
  logic [WORD_W-1:0]    set_word;
  logic [WORD_W-1:0]    clr_word;
  logic [2*NUM_WORDS-1:0] free_dbl;

  logic                 out_valid_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic                 out_full_q;

  // free slots at or after the preferred bit of the captured word
  assign cand       = ~rd_q & ({WORD_W{1'b1}} << bidx_q);
  assign bit_oh     = WORD_W'(1) << bidx_q;
  assign set_word   = rd_q | bit_oh;
  assign clr_word   = rd_q & ~bit_oh;
  assign rot_sh     = widx_q + WIDX_W'(1);
  assign free_dbl   = {~wfull_q, ~wfull_q};
  assign found_widx = widx_q + WIDX_W'(1) + low_word(rot_q);
  assign rd_addr    = cmd_i.rd_found ? found_widx
                                     : req_slot_index_i[SLOT_W-1:BIT_W];

  assign status_o.is_release = (op_q == cffsa_pkg::OP_RELEASE);
  assign status_o.cand_any   = |cand;
  assign status_o.all_full   = &wfull_q;
  assign status_o.out_free   = !out_valid_q || rsp_ready_i;

  // occupancy words, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) mem_q[i] <= '0;
      wfull_q <= '0;
    end else begin
      if (cmd_i.commit_set) begin
        mem_q[widx_q]   <= set_word;
        wfull_q[widx_q] <= &set_word;
      end else if (cmd_i.commit_clr) begin
        mem_q[widx_q]   <= clr_word;
        wfull_q[widx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture || cmd_i.rd_found) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // request and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= req_operation_i;
      widx_q <= req_slot_index_i[SLOT_W-1:BIT_W];
      bidx_q <= req_slot_index_i[BIT_W-1:0];
    end else begin
      if (cmd_i.rd_found) widx_q <= found_widx;
      if (cmd_i.take_cand) bidx_q <= low_bit(cand);
      if (cmd_i.take_free) bidx_q <= low_bit(~rd_q);
    end
    if (cmd_i.rot_en) begin
      rot_q <= free_dbl[rot_sh +: NUM_WORDS];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_set || cmd_i.load_full) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_set) begin
      out_slot_q <= {widx_q, bidx_q};
      out_full_q <= 1'b0;
    end else if (cmd_i.load_full) begin
      out_slot_q <= '0;
      out_full_q <= 1'b1;
    end
  end

  assign rsp_valid_o        = out_valid_q;
  assign rsp_granted_slot_o = out_slot_q;
  assign rsp_table_full_o   = out_full_q;

endmodule
`default_nettype wire

// ===== rtl/core/circular_first_free_slot_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_first_free_slot_allocator
// Grants the preferred slot if free, else the next free slot with wraparound;
// release requests free a slot and return nothing.
// ----------------------------------------------------------------------------
//   channel  dir  payload                       notes
//   req      in   operation, slot_index         0 allocate, 1 release
//   rsp      out  granted_slot, table_full      one per allocate
//
// Release: read word, check, clear bit. Allocate hit in the preferred word:
// read, check, commit; table full: read, check, load full. Word-full search:
// read, check, rotate, read found word, pick its lowest free bit, commit.
// Reset clears all occupancy at once; no clearing pass.
// One request in flight; a new request is taken while a result waits, and
// an allocate holds at commit or table full until the result register is free.
module circular_first_free_slot_allocator (
  input  wire       clk_i,
  input  wire       rst_ni,
  cffsa_req_if.sink   req,
  cffsa_rsp_if.source rsp
);

  cffsa_pkg::cmd_t    cmd;
  cffsa_pkg::status_t status;

  cffsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cffsa_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_operation_i    (req.operation),
    .req_slot_index_i   (req.slot_index),
    .cmd_i              (cmd),
    .status_o           (status),
    .rsp_valid_o        (rsp.valid),
    .rsp_ready_i        (rsp.ready),
    .rsp_granted_slot_o (rsp.granted_slot),
    .rsp_table_full_o   (rsp.table_full)
  );

endmodule
`default_nettype wire

// ===== rtl/core/cffsa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cffsa_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cffsa_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          req_valid_i,
  input wire                          req_ready_i,
  input wire                          rsp_valid_i,
  input wire                          rsp_ready_i,
  input wire [cffsa_pkg::SLOT_W-1:0]  rsp_granted_slot_i,
  input wire                          rsp_table_full_i
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_granted_slot_i)
      && $stable(rsp_table_full_i))
    else $error("stalled result changed");

  // full result never names a slot
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_table_full_i |-> rsp_granted_slot_i == '0)
    else $error("table full with nonzero slot");

  // one request in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // no result can appear right after a transaction is taken
  a_no_early_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !$rose(rsp_valid_i))
    else $error("result too early");

endmodule

bind circular_first_free_slot_allocator cffsa_checker u_cffsa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req.valid),
  .req_ready_i        (req.ready),
  .rsp_valid_i        (rsp.valid),
  .rsp_ready_i        (rsp.ready),
  .rsp_granted_slot_i (rsp.granted_slot),
  .rsp_table_full_i   (rsp.table_full)
);
`default_nettype wire
